// ===== hw/rtl/sta_pkg.sv =====
// Shared types, widths and the solver micro-op table of the similarity fit.
package sta_pkg;

  // Pair limit and stream widths
  localparam int MAX_PAIRS   = 256;
  localparam int CNT_W       = $clog2(MAX_PAIRS + 1);
  localparam int PT_W        = 24;
  localparam int SUM_W       = 32;
  localparam int SQ_W        = 56;
  localparam int CR_W        = 56;
  localparam int OUT_W       = 32;
  localparam int STAT_W      = 2;

  // Solver datapath widths
  localparam int X_W         = 68;   // wide multiplicand (den, numerators)
  localparam int Y_W         = 33;   // narrow multiplier (sums, count)
  localparam int ACC_W       = 104;  // product accumulator
  localparam int ND_W        = 80;   // n * den
  localparam int NUM_W       = 108;  // shifted dividend
  localparam int D_W         = 77;   // divisor
  localparam int DIV_W       = 110;  // remainder and shifted divisor
  localparam int BIT_W       = 6;
  localparam int PC_W        = 4;
  localparam int NUM_OPS     = 16;
  localparam int OP_NUMA     = 3;    // first op after the spread is known
  localparam int A_SHIFT     = 24;
  localparam int T_SHIFT     = 4;

  // Request queue between accumulator and solver
  localparam int QUEUE_DEPTH = 2;
  localparam int QP_W        = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QC_W        = $clog2(QUEUE_DEPTH + 1);

  // Result codes and fixed values
  localparam logic [STAT_W-1:0] ST_OK   = 2'd0;
  localparam logic [STAT_W-1:0] ST_FLAT = 2'd1;
  localparam logic [STAT_W-1:0] ST_OVER = 2'd2;
  localparam logic [OUT_W-1:0]  ONE_Q24 = 32'h0100_0000;
  localparam logic [OUT_W-1:0]  OUT_MAX = 32'h7fff_ffff;
  localparam logic [OUT_W-1:0]  OUT_MIN = 32'h8000_0000;

  // One finished set of sums
  typedef struct packed {
    logic [CNT_W-1:0]        n;
    logic signed [SUM_W-1:0] sfx;
    logic signed [SUM_W-1:0] sfy;
    logic signed [SUM_W-1:0] stx;
    logic signed [SUM_W-1:0] sty;
    logic [SQ_W-1:0]         sq;
    logic signed [CR_W-1:0]  cxx;
    logic signed [CR_W-1:0]  cxy;
    logic signed [CR_W-1:0]  cyx;
    logic signed [CR_W-1:0]  cyy;
    logic                    ovf;
  } job_t;

  typedef enum logic [3:0] {
    X_SQ, X_SFX, X_SFY, X_STX, X_STY, X_CCOS, X_CSIN, X_DEN, X_NUMA, X_NUMB
  } xsel_e;

  typedef enum logic [2:0] {
    Y_N, Y_SFX, Y_SFY, Y_STX, Y_STY
  } ysel_e;

  typedef enum logic [2:0] {
    D_NONE, D_DEN, D_NUMA, D_NUMB, D_T1, D_T2, D_NDEN
  } dst_e;

  typedef struct packed {
    logic  clr;
    xsel_e x;
    ysel_e y;
    logic  sub;
    dst_e  dst;
  } op_t;

  // Multiply-accumulate program: den, numa, numb, t1, t2, n*den
  function automatic op_t op_at(input logic [PC_W-1:0] pc);
    op_t o;
    o = '{clr: 1'b0, x: X_SQ, y: Y_N, sub: 1'b0, dst: D_NONE};
    case (pc)
      4'd0:  o = '{clr: 1'b1, x: X_SQ,   y: Y_N,   sub: 1'b0, dst: D_NONE};
      4'd1:  o = '{clr: 1'b0, x: X_SFX,  y: Y_SFX, sub: 1'b1, dst: D_NONE};
      4'd2:  o = '{clr: 1'b0, x: X_SFY,  y: Y_SFY, sub: 1'b1, dst: D_DEN};
      4'd3:  o = '{clr: 1'b1, x: X_CCOS, y: Y_N,   sub: 1'b0, dst: D_NONE};
      4'd4:  o = '{clr: 1'b0, x: X_STX,  y: Y_SFX, sub: 1'b1, dst: D_NONE};
      4'd5:  o = '{clr: 1'b0, x: X_STY,  y: Y_SFY, sub: 1'b1, dst: D_NUMA};
      4'd6:  o = '{clr: 1'b1, x: X_CSIN, y: Y_N,   sub: 1'b0, dst: D_NONE};
      4'd7:  o = '{clr: 1'b0, x: X_STY,  y: Y_SFX, sub: 1'b1, dst: D_NONE};
      4'd8:  o = '{clr: 1'b0, x: X_STX,  y: Y_SFY, sub: 1'b0, dst: D_NUMB};
      4'd9:  o = '{clr: 1'b1, x: X_DEN,  y: Y_STX, sub: 1'b0, dst: D_NONE};
      4'd10: o = '{clr: 1'b0, x: X_NUMA, y: Y_SFX, sub: 1'b1, dst: D_NONE};
      4'd11: o = '{clr: 1'b0, x: X_NUMB, y: Y_SFY, sub: 1'b0, dst: D_T1};
      4'd12: o = '{clr: 1'b1, x: X_DEN,  y: Y_STY, sub: 1'b0, dst: D_NONE};
      4'd13: o = '{clr: 1'b0, x: X_NUMB, y: Y_SFX, sub: 1'b1, dst: D_NONE};
      4'd14: o = '{clr: 1'b0, x: X_NUMA, y: Y_SFY, sub: 1'b1, dst: D_T2};
      4'd15: o = '{clr: 1'b1, x: X_DEN,  y: Y_N,   sub: 1'b0, dst: D_NDEN};
      default: o = '{clr: 1'b0, x: X_SQ, y: Y_N, sub: 1'b0, dst: D_NONE};
    endcase
    return o;
  endfunction

endpackage

// ===== hw/rtl/similarity_transform_fit_2d.sv =====
// Top level of the streaming 2D similarity-transform fit.
//
// Usage: point pairs enter on the s_axis channel, one request per pair, with
// tlast set on the final pair of a set. The block keeps exact integer sums
// and, on the last pair, fits to = M*from + t with M = [[a,-b],[b,a]].
// One result request per set leaves on m_axis: a and b in Q8.24, t in Q28.4,
// and a status code in tuser (ok, zero source spread, too many pairs).
// The accumulator reuses three 24x24 multipliers for the x and y halves of
// each pair and takes the next pair while it adds the y terms of the last.
// The solver runs a program of 16 multiply-accumulates on a bit-serial
// multiplier, then 4 divisions on a restoring divider; when the source
// spread is zero it stops after the den terms and runs only the two offset
// divisions. A two-entry queue lets the next set accumulate meanwhile; the
// input stalls on the hand-off of a set only when the queue is full.
// Reset clears sums, queue and result valid; nothing is pending after it.
// A stalled receiver holds the result in the output register while the
// solver and the accumulator go on until the queue fills.
module similarity_transform_fit_2d (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  input  logic [95:0]  s_axis_tdata_i,   // src_x, src_y, dst_x, dst_y
  input  logic         s_axis_tlast_i,   // last_point
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  output logic [127:0] m_axis_tdata_o,   // scale_cos, scale_sin, offset_x, offset_y
  output logic [1:0]   m_axis_tuser_o    // fit_status
);

  localparam int PT_W  = sta_pkg::PT_W;
  localparam int OUT_W = sta_pkg::OUT_W;

  logic          push_valid, push_ready, pop_valid, pop;
  sta_pkg::job_t push_job, head_job;

  sta_accum u_accum (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .pair_valid_i (s_axis_tvalid_i),
    .pair_ready_o (s_axis_tready_o),
    .src_x_i      (s_axis_tdata_i[PT_W-1:0]),
    .src_y_i      (s_axis_tdata_i[2*PT_W-1:PT_W]),
    .dst_x_i      (s_axis_tdata_i[3*PT_W-1:2*PT_W]),
    .dst_y_i      (s_axis_tdata_i[4*PT_W-1:3*PT_W]),
    .last_i       (s_axis_tlast_i),
    .job_valid_o  (push_valid),
    .job_ready_i  (push_ready),
    .job_o        (push_job)
  );

  sta_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_data_i  (push_job),
    .pop_valid_o  (pop_valid),
    .pop_i        (pop),
    .pop_data_o   (head_job)
  );

  sta_solve u_solve (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .job_valid_i  (pop_valid),
    .job_ready_o  (pop),
    .job_i        (head_job),
    .res_valid_o  (m_axis_tvalid_o),
    .res_ready_i  (m_axis_tready_i),
    .scale_cos_o  (m_axis_tdata_o[OUT_W-1:0]),
    .scale_sin_o  (m_axis_tdata_o[2*OUT_W-1:OUT_W]),
    .offset_x_o   (m_axis_tdata_o[3*OUT_W-1:2*OUT_W]),
    .offset_y_o   (m_axis_tdata_o[4*OUT_W-1:3*OUT_W]),
    .fit_status_o (m_axis_tuser_o)
  );

endmodule

// ===== hw/rtl/sta_accum.sv =====
// Front end: accepts point pairs and accumulates exact sums, x terms then y terms.
module sta_accum (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          pair_valid_i,
  output logic                          pair_ready_o,
  input  logic signed [sta_pkg::PT_W-1:0] src_x_i,
  input  logic signed [sta_pkg::PT_W-1:0] src_y_i,
  input  logic signed [sta_pkg::PT_W-1:0] dst_x_i,
  input  logic signed [sta_pkg::PT_W-1:0] dst_y_i,
  input  logic                          last_i,
  output logic                          job_valid_o,
  input  logic                          job_ready_i,
  output sta_pkg::job_t                 job_o
);

  localparam int PT_W  = sta_pkg::PT_W;
  localparam int P_W   = 2 * PT_W;
  localparam int CNT_W = sta_pkg::CNT_W;
  localparam int SUM_W = sta_pkg::SUM_W;
  localparam int SQ_W  = sta_pkg::SQ_W;
  localparam int CR_W  = sta_pkg::CR_W;

  logic busy_q, busy_d, ph_q, ph_d, take_q, take_d;
  logic last_q;
  logic signed [PT_W-1:0] sx_q, sy_q, dx_q, dy_q;
  sta_pkg::job_t sums_q, nxt, sums_d;

  logic signed [PT_W-1:0] mul_a;
  logic signed [P_W-1:0]  p_sq, p_dx, p_dy;
  logic step_a, step_b, take_now, done, accept;

  // Square and cross products of the current coordinate
  always_comb begin
    mul_a = ph_q ? sy_q : sx_q;
    p_sq  = mul_a * mul_a;
    p_dx  = mul_a * dx_q;
    p_dy  = mul_a * dy_q;
  end

  // Add x terms in the first phase and y terms in the second
  always_comb begin
    step_a   = busy_q & ~ph_q;
    step_b   = busy_q & ph_q;
    take_now = (sums_q.n < CNT_W'(sta_pkg::MAX_PAIRS));
    take_d   = take_q;
    nxt      = sums_q;
    if (step_a) begin
      take_d = take_now;
      if (take_now) begin
        nxt.n   = sums_q.n + 1'b1;
        nxt.sfx = sums_q.sfx + SUM_W'(sx_q);
        nxt.stx = sums_q.stx + SUM_W'(dx_q);
        nxt.sq  = sums_q.sq + SQ_W'($unsigned(p_sq));
        nxt.cxx = sums_q.cxx + CR_W'(p_dx);
        nxt.cxy = sums_q.cxy + CR_W'(p_dy);
      end else begin
        nxt.ovf = 1'b1;
      end
    end
    if (step_b && take_q) begin
      nxt.sfy = sums_q.sfy + SUM_W'(sy_q);
      nxt.sty = sums_q.sty + SUM_W'(dy_q);
      nxt.sq  = sums_q.sq + SQ_W'($unsigned(p_sq));
      nxt.cyx = sums_q.cyx + CR_W'(p_dx);
      nxt.cyy = sums_q.cyy + CR_W'(p_dy);
    end
  end

  // Hand the set over on the last pair, then clear; hold the sums while stalled
  always_comb begin
    job_o        = nxt;
    job_valid_o  = step_b & last_q;
    done         = step_b & (~last_q | job_ready_i);
    pair_ready_o = ~busy_q | done;
    accept       = pair_valid_i & pair_ready_o;
    if (step_b && !done) begin
      sums_d = sums_q;
    end else begin
      sums_d = (done && last_q) ? '0 : nxt;
    end
    busy_d       = accept ? 1'b1 : (done ? 1'b0 : busy_q);
    ph_d         = accept ? 1'b0 : (step_a ? 1'b1 : ph_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      ph_q   <= 1'b0;
      take_q <= 1'b0;
      sums_q <= '0;
    end else begin
      busy_q <= busy_d;
      ph_q   <= ph_d;
      take_q <= take_d;
      sums_q <= sums_d;
    end
  end

  // Capture the pair payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      sx_q   <= src_x_i;
      sy_q   <= src_y_i;
      dx_q   <= dst_x_i;
      dy_q   <= dst_y_i;
      last_q <= last_i;
    end
  end

endmodule

// ===== hw/rtl/sta_fifo.sv =====
// Short request queue of finished sum sets between accumulator and solver.
module sta_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_valid_i,
  output logic          push_ready_o,
  input  sta_pkg::job_t push_data_i,
  output logic          pop_valid_o,
  input  logic          pop_i,
  output sta_pkg::job_t pop_data_o
);

  localparam int DEPTH = sta_pkg::QUEUE_DEPTH;
  localparam int QP_W  = sta_pkg::QP_W;
  localparam int QC_W  = sta_pkg::QC_W;

  sta_pkg::job_t mem_q [DEPTH];
  logic [QP_W-1:0] wptr_q, wptr_d, rptr_q, rptr_d;
  logic [QC_W-1:0] cnt_q, cnt_d;
  logic push, pop;

  // Track fill level and wrap the pointers
  always_comb begin
    push_ready_o = (cnt_q != QC_W'(DEPTH));
    pop_valid_o  = (cnt_q != '0);
    push         = push_valid_i & push_ready_o;
    pop          = pop_i & pop_valid_o;
    pop_data_o   = mem_q[rptr_q];
    wptr_d       = wptr_q;
    rptr_d       = rptr_q;
    if (push) begin
      wptr_d = (wptr_q == QP_W'(DEPTH - 1)) ? '0 : wptr_q + 1'b1;
    end
    if (pop) begin
      rptr_d = (rptr_q == QP_W'(DEPTH - 1)) ? '0 : rptr_q + 1'b1;
    end
    cnt_d = cnt_q + QC_W'(push) - QC_W'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  // Write the incoming request
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wptr_q] <= push_data_i;
    end
  end

endmodule

// ===== hw/rtl/sta_solve.sv =====
// Back end: solves the fit with a shift-add multiplier and a restoring divider.
module sta_solve (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         job_valid_i,
  output logic                         job_ready_o,
  input  sta_pkg::job_t                job_i,
  output logic                         res_valid_o,
  input  logic                         res_ready_i,
  output logic [sta_pkg::OUT_W-1:0]    scale_cos_o,
  output logic [sta_pkg::OUT_W-1:0]    scale_sin_o,
  output logic [sta_pkg::OUT_W-1:0]    offset_x_o,
  output logic [sta_pkg::OUT_W-1:0]    offset_y_o,
  output logic [sta_pkg::STAT_W-1:0]   fit_status_o
);

  localparam int X_W   = sta_pkg::X_W;
  localparam int Y_W   = sta_pkg::Y_W;
  localparam int ACC_W = sta_pkg::ACC_W;
  localparam int ND_W  = sta_pkg::ND_W;
  localparam int NUM_W = sta_pkg::NUM_W;
  localparam int D_W   = sta_pkg::D_W;
  localparam int DIV_W = sta_pkg::DIV_W;
  localparam int Q_W   = sta_pkg::OUT_W;
  localparam int BIT_W = sta_pkg::BIT_W;
  localparam int PC_W  = sta_pkg::PC_W;
  localparam int OUT_W = sta_pkg::OUT_W;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_LOAD  = 6'b000010,
    S_MAC   = 6'b000100,
    S_DIVLD = 6'b001000,
    S_DIV   = 6'b010000,
    S_OUT   = 6'b100000
  } state_e;

  typedef enum logic [1:0] {DV_A, DV_B, DV_TX, DV_TY} div_e;

  state_e state_q, state_d;
  div_e   didx_q, didx_d;
  logic [PC_W-1:0]  pc_q, pc_d;
  logic [BIT_W-1:0] bit_q, bit_d, dstep_q, dstep_d;
  logic             sub_q, sub_d, flat_q, flat_d, neg_q, neg_d, sat_q, sat_d;
  logic             out_valid_q, out_valid_d;
  logic signed [ACC_W-1:0] acc_q, acc_d, mx_q, mx_d, t1_q, t1_d, t2_q, t2_d;
  logic signed [X_W-1:0]   den_q, den_d, numa_q, numa_d, numb_q, numb_d;
  logic [ND_W-1:0]  nden_q, nden_d;
  logic [Y_W-1:0]   my_q, my_d;
  logic [DIV_W-1:0] rem_q, rem_d, ds_q, ds_d;
  logic [Q_W-1:0]   quo_q, quo_d;
  logic [OUT_W-1:0] ra_q, ra_d, rb_q, rb_d, rtx_q, rtx_d, rty_q, rty_d;
  logic [OUT_W-1:0] oa_q, ob_q, otx_q, oty_q;
  logic [sta_pkg::STAT_W-1:0] ost_q, st_now;

  sta_pkg::op_t op;
  logic signed [X_W-1:0]   xv;
  logic signed [Y_W-1:0]   yv;
  logic signed [ACC_W-1:0] acc_sum;
  logic signed [NUM_W-1:0] num;
  logic [NUM_W-1:0]        mag;
  logic [D_W-1:0]          dvs;
  logic [Q_W-1:0]          q_fin, res_val;
  logic add_neg, ge, out_load;

  // Operand selection for the current micro-op
  always_comb begin
    op = sta_pkg::op_at(pc_q);
    case (op.x)
      sta_pkg::X_SQ:   xv = X_W'(job_i.sq);
      sta_pkg::X_SFX:  xv = X_W'($signed(job_i.sfx));
      sta_pkg::X_SFY:  xv = X_W'($signed(job_i.sfy));
      sta_pkg::X_STX:  xv = X_W'($signed(job_i.stx));
      sta_pkg::X_STY:  xv = X_W'($signed(job_i.sty));
      sta_pkg::X_CCOS: xv = X_W'($signed(job_i.cxx)) + X_W'($signed(job_i.cyy));
      sta_pkg::X_CSIN: xv = X_W'($signed(job_i.cxy)) - X_W'($signed(job_i.cyx));
      sta_pkg::X_DEN:  xv = den_q;
      sta_pkg::X_NUMA: xv = numa_q;
      sta_pkg::X_NUMB: xv = numb_q;
      default:         xv = '0;
    endcase
    case (op.y)
      sta_pkg::Y_N:   yv = Y_W'(job_i.n);
      sta_pkg::Y_SFX: yv = Y_W'($signed(job_i.sfx));
      sta_pkg::Y_SFY: yv = Y_W'($signed(job_i.sfy));
      sta_pkg::Y_STX: yv = Y_W'($signed(job_i.stx));
      sta_pkg::Y_STY: yv = Y_W'($signed(job_i.sty));
      default:        yv = '0;
    endcase
  end

  // One shift-add step; the top multiplier bit carries negative weight
  always_comb begin
    add_neg = sub_q ^ (bit_q == BIT_W'(Y_W - 1));
    if (my_q[0]) begin
      acc_sum = add_neg ? (acc_q - mx_q) : (acc_q + mx_q);
    end else begin
      acc_sum = acc_q;
    end
  end

  // Dividend and divisor of the current division
  always_comb begin
    case (didx_q)
      DV_A:    num = NUM_W'(numa_q) << sta_pkg::A_SHIFT;
      DV_B:    num = NUM_W'(numb_q) << sta_pkg::A_SHIFT;
      DV_TX:   num = flat_q
                     ? (NUM_W'($signed(job_i.stx)) - NUM_W'($signed(job_i.sfx)))
                       << sta_pkg::T_SHIFT
                     : NUM_W'(t1_q) << sta_pkg::T_SHIFT;
      DV_TY:   num = flat_q
                     ? (NUM_W'($signed(job_i.sty)) - NUM_W'($signed(job_i.sfy)))
                       << sta_pkg::T_SHIFT
                     : NUM_W'(t2_q) << sta_pkg::T_SHIFT;
      default: num = '0;
    endcase
    if (didx_q == DV_A || didx_q == DV_B) begin
      dvs = D_W'($unsigned(den_q));
    end else begin
      dvs = flat_q ? D_W'(job_i.n) : D_W'(nden_q);
    end
    mag = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
  end

  // Restoring step, rounding already folded into the operands
  always_comb begin
    ge    = (rem_q >= ds_q);
    q_fin = {quo_q[Q_W-2:0], ge};
    if (sat_q || q_fin[Q_W-1]) begin
      res_val = neg_q ? sta_pkg::OUT_MIN : sta_pkg::OUT_MAX;
    end else begin
      res_val = neg_q ? Q_W'(-q_fin) : q_fin;
    end
    if (job_i.ovf) begin
      st_now = sta_pkg::ST_OVER;
    end else begin
      st_now = flat_q ? sta_pkg::ST_FLAT : sta_pkg::ST_OK;
    end
  end

  // Sequence the multiply program, the divisions and the hand-off
  always_comb begin
    state_d     = state_q;
    didx_d      = didx_q;
    pc_d        = pc_q;
    bit_d       = bit_q;
    dstep_d     = dstep_q;
    sub_d       = sub_q;
    flat_d      = flat_q;
    neg_d       = neg_q;
    sat_d       = sat_q;
    acc_d       = acc_q;
    mx_d        = mx_q;
    my_d        = my_q;
    t1_d        = t1_q;
    t2_d        = t2_q;
    den_d       = den_q;
    numa_d      = numa_q;
    numb_d      = numb_q;
    nden_d      = nden_q;
    rem_d       = rem_q;
    ds_d        = ds_q;
    quo_d       = quo_q;
    ra_d        = ra_q;
    rb_d        = rb_q;
    rtx_d       = rtx_q;
    rty_d       = rty_q;
    out_load    = 1'b0;
    job_ready_o = 1'b0;
    out_valid_d = out_valid_q & ~res_ready_i;
    case (state_q)
      S_IDLE: begin
        if (job_valid_i) begin
          pc_d    = '0;
          flat_d  = 1'b0;
          state_d = S_LOAD;
        end
      end
      S_LOAD: begin
        if (pc_q == PC_W'(sta_pkg::OP_NUMA) && den_q == '0) begin
          flat_d  = 1'b1;
          ra_d    = sta_pkg::ONE_Q24;
          rb_d    = '0;
          didx_d  = DV_TX;
          state_d = S_DIVLD;
        end else begin
          mx_d    = ACC_W'(xv);
          my_d    = yv;
          bit_d   = '0;
          sub_d   = op.sub;
          if (op.clr) begin
            acc_d = '0;
          end
          state_d = S_MAC;
        end
      end
      S_MAC: begin
        acc_d = acc_sum;
        mx_d  = mx_q <<< 1;
        my_d  = my_q >> 1;
        bit_d = bit_q + 1'b1;
        if (bit_q == BIT_W'(Y_W - 1)) begin
          case (op.dst)
            sta_pkg::D_DEN:  den_d  = X_W'(acc_sum);
            sta_pkg::D_NUMA: numa_d = X_W'(acc_sum);
            sta_pkg::D_NUMB: numb_d = X_W'(acc_sum);
            sta_pkg::D_T1:   t1_d   = acc_sum;
            sta_pkg::D_T2:   t2_d   = acc_sum;
            sta_pkg::D_NDEN: nden_d = ND_W'(acc_sum);
            default: ;
          endcase
          if (pc_q == PC_W'(sta_pkg::NUM_OPS - 1)) begin
            didx_d  = DV_A;
            state_d = S_DIVLD;
          end else begin
            pc_d    = pc_q + 1'b1;
            state_d = S_LOAD;
          end
        end
      end
      S_DIVLD: begin
        neg_d   = num[NUM_W-1];
        rem_d   = (DIV_W'(mag) << 1) + DIV_W'(dvs);
        ds_d    = DIV_W'(dvs) << (Q_W + 1);
        quo_d   = '0;
        sat_d   = 1'b0;
        dstep_d = '0;
        state_d = S_DIV;
      end
      S_DIV: begin
        ds_d    = ds_q >> 1;
        dstep_d = dstep_q + 1'b1;
        if (dstep_q == '0) begin
          sat_d = ge;
        end else begin
          quo_d = q_fin;
          if (ge) begin
            rem_d = rem_q - ds_q;
          end
        end
        if (dstep_q == BIT_W'(Q_W)) begin
          case (didx_q)
            DV_A:    ra_d  = res_val;
            DV_B:    rb_d  = res_val;
            DV_TX:   rtx_d = res_val;
            DV_TY:   rty_d = res_val;
            default: ;
          endcase
          if (didx_q == DV_TY) begin
            state_d = S_OUT;
          end else begin
            didx_d  = div_e'(didx_q + 1'b1);
            state_d = S_DIVLD;
          end
        end
      end
      S_OUT: begin
        if (!out_valid_q || res_ready_i) begin
          out_load    = 1'b1;
          out_valid_d = 1'b1;
          job_ready_o = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      didx_q      <= DV_A;
      pc_q        <= '0;
      bit_q       <= '0;
      dstep_q     <= '0;
      flat_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      didx_q      <= didx_d;
      pc_q        <= pc_d;
      bit_q       <= bit_d;
      dstep_q     <= dstep_d;
      flat_q      <= flat_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    sub_q  <= sub_d;
    neg_q  <= neg_d;
    sat_q  <= sat_d;
    acc_q  <= acc_d;
    mx_q   <= mx_d;
    my_q   <= my_d;
    t1_q   <= t1_d;
    t2_q   <= t2_d;
    den_q  <= den_d;
    numa_q <= numa_d;
    numb_q <= numb_d;
    nden_q <= nden_d;
    rem_q  <= rem_d;
    ds_q   <= ds_d;
    quo_q  <= quo_d;
    ra_q   <= ra_d;
    rb_q   <= rb_d;
    rtx_q  <= rtx_d;
    rty_q  <= rty_d;
  end

  // Output register
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      oa_q  <= ra_q;
      ob_q  <= rb_q;
      otx_q <= rtx_q;
      oty_q <= rty_q;
      ost_q <= st_now;
    end
  end

  assign res_valid_o  = out_valid_q;
  assign scale_cos_o  = oa_q;
  assign scale_sin_o  = ob_q;
  assign offset_x_o   = otx_q;
  assign offset_y_o   = oty_q;
  assign fit_status_o = ost_q;

endmodule

// ===== hw/rtl/sta_checker.sv =====
// Port-level checks of the similarity fit, bound to the top level.
module sta_checker (
  input logic         clk_i,
  input logic         rst_ni,
  input logic         s_axis_tvalid_i,
  input logic         s_axis_tready_o,
  input logic [95:0]  s_axis_tdata_i,
  input logic         s_axis_tlast_i,
  input logic         m_axis_tvalid_o,
  input logic         m_axis_tready_i,
  input logic [127:0] m_axis_tdata_o,
  input logic [1:0]   m_axis_tuser_o
);

  // Hold a stalled result
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o))
    else $error("stalled result changed");

  // Status never takes the unused code
  a_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> m_axis_tuser_o != 2'd3)
    else $error("undefined fit status");

  // Zero spread gives the identity matrix
  a_flat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o == sta_pkg::ST_FLAT |->
      m_axis_tdata_o[31:0] == sta_pkg::ONE_Q24 && m_axis_tdata_o[63:32] == 32'd0)
    else $error("zero spread result is not the identity");

endmodule

bind similarity_transform_fit_2d sta_checker u_checker (.*);
